@@ design/glpd_pkg.sv @@
`default_nettype none
package glpd_pkg;

   localparam int CODE_W            = 13;
   localparam int DEF_TABLE_DEPTH   = 4096;
   localparam int DEF_MAX_CODE_BITS = 12;
   localparam int DEF_STRING_DEPTH  = 4096;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [3:0] CFG_RESET  = 4'd8;
   localparam logic [3:0] ROOT_LOW   = 4'd2;
   localparam logic [3:0] ROOT_HIGH  = 4'd8;
   localparam logic [11:0] LEN_MAX   = 12'd4095;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CODE = 2'd1;
   localparam logic [1:0] ST_ZERO_LEN = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_PULL    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef struct packed {
      op_type      opcode;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  pixel;
      logic        pixel_valid;
      logic        byte_accepted;
      logic        need_byte;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [11:0] prefix;
      logic [7:0]  suffix;
      logic [11:0] len;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PULL,
      S_KW,
      S_WALK,
      S_PIX,
      S_SEND
   } state_type;

   function automatic logic [3:0] root_bits(input logic [3:0] m);
      logic [3:0] r;
      r = m;
      if (m < ROOT_LOW) r = ROOT_LOW;
      if (m > ROOT_HIGH) r = ROOT_HIGH;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/glpd_front.sv @@
`default_nettype none
module glpd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire glpd_pkg::req_type req_payload,
   output logic                   q_valid,
   output glpd_pkg::req_type      q_item,
   input  wire logic              q_pop
);

   glpd_pkg::req_type slot_ff [glpd_pkg::QUEUE_DEPTH];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'(glpd_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = q_pop ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= req_payload;
      end
   end

endmodule
`default_nettype wire

@@ design/glpd_back.sv @@
`default_nettype none
module glpd_back #(
   parameter int TABLE_DEPTH   = glpd_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_CODE_BITS = glpd_pkg::DEF_MAX_CODE_BITS,
   parameter int STRING_DEPTH  = glpd_pkg::DEF_STRING_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [3:0]        cfg_min,
   input  wire logic              q_valid,
   input  wire glpd_pkg::req_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output glpd_pkg::rsp_type      rsp_payload
);

   localparam int CW  = glpd_pkg::CODE_W;
   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int SAW = $clog2(STRING_DEPTH);
   localparam int CODE_LIMIT = ((1 << MAX_CODE_BITS) < TABLE_DEPTH) ?
                               (1 << MAX_CODE_BITS) : TABLE_DEPTH;
   localparam logic [3:0] RST_ROOT = glpd_pkg::root_bits(glpd_pkg::CFG_RESET);

   glpd_pkg::state_type state_ff, state_in;

   logic [CW-1:0] str_len_ff, str_len_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] nfc_ff, nfc_in;
   logic [3:0]    width_ff, width_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic [11:0]   prev_len_ff, prev_len_in;
   logic [7:0]    prev_first_ff, prev_first_in;
   logic [23:0]   acc_ff, acc_in;
   logic [4:0]    bc_ff, bc_in;
   logic [7:0]    sub_ff, sub_in;
   logic [1:0]    err_ff, err_in;
   logic [CW-1:0] code_ff, code_in;
   logic          add_ff, add_in;
   logic          first_ff, first_in;
   logic [11:0]   widx_ff, widx_in;
   logic [11:0]   cur_len_ff, cur_len_in;
   logic          pix_zero_ff, pix_zero_in;
   glpd_pkg::rsp_type pend_ff, pend_in;
   glpd_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   glpd_pkg::entry_type dict_mem [TABLE_DEPTH];
   glpd_pkg::entry_type dict_rd_ff;
   logic                dict_lit_ff;
   logic [7:0]          dict_addr_ff;
   logic [CW-1:0]       dict_raddr, dict_waddr;
   logic                dict_we;
   glpd_pkg::entry_type dict_wdata;

   logic [7:0]     buf_mem [STRING_DEPTH];
   logic [7:0]     buf_rd_ff;
   logic [SAW-1:0] buf_raddr, buf_waddr;
   logic           buf_we;
   logic [7:0]     buf_wdata;

   logic [3:0]    root;
   logic [CW-1:0] clr, eoi, nfc_p1, grow_n;
   logic [23:0]   mask;
   logic [CW-1:0] code_c;
   logic          have_bits, str_left, room, prev_ok;
   logic          is_clr, is_end, is_known, is_kw;
   logic          walk_last, out_free, grow_hit;
   logic [11:0]   walk_idx_c, prev_len_p1;
   glpd_pkg::entry_type ent;

   assign root        = glpd_pkg::root_bits(cfg_min);
   assign clr         = CW'(1) << root;
   assign eoi         = clr + CW'(1);
   assign mask        = (24'(1) << width_ff) - 24'(1);
   assign code_c      = CW'(acc_ff & mask);
   assign have_bits   = (bc_ff >= {1'b0, width_ff});
   assign str_left    = (pos_ff < str_len_ff);
   assign nfc_p1      = nfc_ff + CW'(1);
   assign room        = (nfc_p1 < CW'(CODE_LIMIT));
   assign prev_ok     = (prev_ff != clr);
   assign is_clr      = (code_c == clr);
   assign is_end      = (code_c == eoi);
   assign is_known    = (code_c <= nfc_ff);
   assign is_kw       = (code_c == nfc_p1) && prev_ok && room;
   assign ent         = dict_lit_ff ?
                        glpd_pkg::entry_type'{prefix: 12'd0, suffix: dict_addr_ff, len: 12'd0}
                                    : dict_rd_ff;
   assign walk_idx_c  = first_ff ? ent.len : widx_ff;
   assign walk_last   = (walk_idx_c == 12'd0);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign prev_len_p1 = (prev_len_ff == glpd_pkg::LEN_MAX) ? glpd_pkg::LEN_MAX
                                                             : prev_len_ff + 12'd1;
   assign grow_n      = add_ff ? nfc_p1 : nfc_ff;
   assign grow_hit    = (grow_n + CW'(1) == limit_ff) && (width_ff < 4'(MAX_CODE_BITS));

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         glpd_pkg::S_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.opcode == glpd_pkg::OP_PULL) ? glpd_pkg::S_PULL
                                                                : glpd_pkg::S_SEND;
            end
         end
         glpd_pkg::S_PULL: begin
            if (err_ff != glpd_pkg::ST_OK) state_in = glpd_pkg::S_SEND;
            else if (str_left) state_in = glpd_pkg::S_PIX;
            else if (!have_bits) state_in = glpd_pkg::S_SEND;
            else if (is_clr || is_end) state_in = glpd_pkg::S_PULL;
            else if (is_known) state_in = glpd_pkg::S_WALK;
            else if (is_kw) state_in = glpd_pkg::S_KW;
            else state_in = glpd_pkg::S_SEND;
         end
         glpd_pkg::S_KW: state_in = glpd_pkg::S_WALK;
         glpd_pkg::S_WALK: begin
            if (walk_last) state_in = glpd_pkg::S_PULL;
         end
         glpd_pkg::S_PIX: state_in = glpd_pkg::S_SEND;
         glpd_pkg::S_SEND: begin
            if (out_free) state_in = glpd_pkg::S_IDLE;
         end
         default: state_in = glpd_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      str_len_in    = str_len_ff;
      pos_in        = pos_ff;
      nfc_in        = nfc_ff;
      width_in      = width_ff;
      limit_in      = limit_ff;
      prev_in       = prev_ff;
      prev_len_in   = prev_len_ff;
      prev_first_in = prev_first_ff;
      acc_in        = acc_ff;
      bc_in         = bc_ff;
      sub_in        = sub_ff;
      err_in        = err_ff;
      code_in       = code_ff;
      add_in        = add_ff;
      first_in      = first_ff;
      widx_in       = widx_ff;
      cur_len_in    = cur_len_ff;
      pix_zero_in   = pix_zero_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      q_pop         = 1'b0;
      dict_raddr    = code_ff;
      dict_we       = 1'b0;
      dict_waddr    = nfc_p1;
      dict_wdata    = '{prefix: prev_ff[11:0], suffix: prev_first_ff, len: prev_len_p1};
      buf_raddr     = pos_ff[SAW-1:0];
      buf_we        = 1'b0;
      buf_waddr     = walk_idx_c[SAW-1:0];
      buf_wdata     = ent.suffix;
      case (state_ff)
         glpd_pkg::S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               pend_in = '0;
               case (q_item.opcode)
                  glpd_pkg::OP_PUSH: begin
                     if (err_ff != glpd_pkg::ST_OK) begin
                        pend_in.byte_accepted = 1'b1;
                     end else if (sub_ff == 8'd0) begin
                        pend_in.byte_accepted = 1'b1;
                        if (q_item.data_byte == 8'd0) err_in = glpd_pkg::ST_ZERO_LEN;
                        else sub_in = q_item.data_byte;
                     end else if (bc_ff <= 5'd16) begin
                        pend_in.byte_accepted = 1'b1;
                        acc_in = acc_ff | (24'(q_item.data_byte) << bc_ff);
                        bc_in  = bc_ff + 5'd8;
                        sub_in = sub_ff - 8'd1;
                     end
                     pend_in.status = err_in;
                  end
                  glpd_pkg::OP_RESTART: begin
                     str_len_in = '0;
                     pos_in     = '0;
                     acc_in     = '0;
                     bc_in      = '0;
                     sub_in     = '0;
                     err_in     = glpd_pkg::ST_OK;
                     width_in   = root + 4'd1;
                     nfc_in     = clr + CW'(1);
                     limit_in   = clr << 1;
                     prev_in    = clr;
                     pend_in.status = glpd_pkg::ST_OK;
                  end
                  default: pend_in.status = err_ff;
               endcase
            end
         end
         glpd_pkg::S_PULL: begin
            pend_in = '0;
            pend_in.status = err_ff;
            if (err_ff != glpd_pkg::ST_OK) begin
               pend_in.status = err_ff;
            end else if (str_left) begin
               pix_zero_in = (pos_ff >= CW'(STRING_DEPTH));
            end else if (!have_bits) begin
               pend_in.need_byte = 1'b1;
            end else begin
               acc_in = acc_ff >> width_ff;
               bc_in  = bc_ff - {1'b0, width_ff};
               if (is_clr) begin
                  width_in = root + 4'd1;
                  nfc_in   = clr + CW'(1);
                  limit_in = clr << 1;
                  prev_in  = clr;
               end else if (is_end) begin
                  code_in = code_ff;
               end else if (is_known) begin
                  dict_raddr = code_c;
                  code_in    = code_c;
                  add_in     = prev_ok && room;
                  first_in   = 1'b1;
               end else if (is_kw) begin
                  dict_we    = 1'b1;
                  dict_waddr = code_c;
                  nfc_in     = code_c;
                  code_in    = code_c;
                  add_in     = 1'b0;
                  first_in   = 1'b1;
               end else begin
                  err_in = glpd_pkg::ST_BAD_CODE;
                  pend_in.status = glpd_pkg::ST_BAD_CODE;
               end
            end
         end
         glpd_pkg::S_KW: begin
            dict_raddr = code_ff;
         end
         glpd_pkg::S_WALK: begin
            first_in = 1'b0;
            if (first_ff) begin
               str_len_in = {1'b0, ent.len} + CW'(1);
               pos_in     = '0;
               cur_len_in = ent.len;
            end
            buf_we = ({1'b0, walk_idx_c} < CW'(STRING_DEPTH));
            if (walk_last) begin
               prev_in       = code_ff;
               prev_len_in   = first_ff ? ent.len : cur_len_ff;
               prev_first_in = ent.suffix;
               if (add_ff) begin
                  dict_we    = 1'b1;
                  dict_waddr = nfc_p1;
                  dict_wdata = '{prefix: prev_ff[11:0], suffix: ent.suffix, len: prev_len_p1};
                  nfc_in     = nfc_p1;
               end
               if (grow_hit) begin
                  width_in = width_ff + 4'd1;
                  limit_in = limit_ff << 1;
               end
            end else begin
               widx_in    = walk_idx_c - 12'd1;
               dict_raddr = {1'b0, ent.prefix};
            end
         end
         glpd_pkg::S_PIX: begin
            pend_in = '0;
            pend_in.pixel       = pix_zero_ff ? 8'd0 : buf_rd_ff;
            pend_in.pixel_valid = 1'b1;
            pend_in.status      = err_ff;
            pos_in              = pos_ff + CW'(1);
         end
         glpd_pkg::S_SEND: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glpd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         str_len_ff   <= '0;
         pos_ff       <= '0;
         acc_ff       <= '0;
         bc_ff        <= '0;
         sub_ff       <= '0;
         err_ff       <= glpd_pkg::ST_OK;
         width_ff     <= RST_ROOT + 4'd1;
         nfc_ff       <= (CW'(1) << RST_ROOT) + CW'(1);
         limit_ff     <= CW'(1) << (RST_ROOT + 4'd1);
         prev_ff      <= CW'(1) << RST_ROOT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         str_len_ff   <= str_len_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         bc_ff        <= bc_in;
         sub_ff       <= sub_in;
         err_ff       <= err_in;
         width_ff     <= width_in;
         nfc_ff       <= nfc_in;
         limit_ff     <= limit_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_len_ff   <= prev_len_in;
      prev_first_ff <= prev_first_in;
      code_ff       <= code_in;
      add_ff        <= add_in;
      first_ff      <= first_in;
      widx_ff       <= widx_in;
      cur_len_ff    <= cur_len_in;
      pix_zero_ff   <= pix_zero_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   // dictionary and string memories
   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[dict_waddr[TAW-1:0]] <= dict_wdata;
      end
      dict_rd_ff   <= dict_mem[dict_raddr[TAW-1:0]];
      dict_lit_ff  <= (dict_raddr < clr);
      dict_addr_ff <= dict_raddr[7:0];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rd_ff <= buf_mem[buf_raddr];
   end

endmodule
`default_nettype wire

@@ design/gif_lzw_pixel_decoder_top.sv @@
`default_nettype none
// GIF LZW pixel decoder. Requests enter a two-deep queue and are executed one
// at a time; each request gives exactly one response. A pull that finds a
// buffered pixel reads it from the string memory. A pull that must decode a
// code takes each code from the bit accumulator and then walks the decoded
// string's dictionary chain one character at a time through the single read
// port of the table memory (a KwKwK code adds one more step). The dictionary's
// literal entries are formed from the code itself, so no clearing pass follows
// reset. min_code_size must be written through the csr port only while the
// block is idle; the block itself does not enforce this.
module gif_lzw_pixel_decoder_top #(
   parameter int TABLE_DEPTH   = glpd_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_CODE_BITS = glpd_pkg::DEF_MAX_CODE_BITS,
   parameter int STRING_DEPTH  = glpd_pkg::DEF_STRING_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire glpd_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output glpd_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [3:0]        csr_data
);

   logic [3:0]        min_code_ff, min_code_in;
   logic              q_valid, q_pop;
   glpd_pkg::req_type q_item;

   assign csr_ready   = 1'b1;
   assign min_code_in = (csr_valid && csr_ready) ? csr_data : min_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_code_ff <= glpd_pkg::CFG_RESET;
      end else begin
         min_code_ff <= min_code_in;
      end
   end

   glpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   glpd_back #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .STRING_DEPTH  (STRING_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_min     (min_code_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ tb/tb_gif_lzw_pixel_decoder_top.sv @@
`default_nettype none
module tb_gif_lzw_pixel_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   glpd_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   glpd_pkg::rsp_type rsp_payload;
   logic csr_valid;
   logic csr_ready;
   logic [3:0] csr_data;

   gif_lzw_pixel_decoder_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   typedef struct {
      glpd_pkg::op_type  op;
      logic [7:0]        data;
      bit                typed;
      glpd_pkg::rsp_type rsp;
   } plan_row_type;

   // decoder shadow state
   logic [11:0] dict_prefix [4096];
   logic [7:0]  dict_suffix [4096];
   logic [11:0] dict_len    [4096];
   logic [7:0]  str_buf     [4096];
   int unsigned str_len, str_pos, last_code, width, grow_at, prev_code;
   int unsigned bit_acc, bit_cnt, block_left, err_state, min_size;

   glpd_pkg::rsp_type due_rsp_q [$];
   logic [7:0]        stream_q [$];
   plan_row_type      plan [$];
   int          fail_cnt = 0;
   int          rsp_cnt = 0;
   int          req_cnt = 0;
   int          pixel_cnt = 0;
   bit          send_idle = 0;
   bit          recv_idle = 0;
   int          recv_pct = 0;
   int          send_pct = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned root_of(int unsigned m);
      if (m < glpd_pkg::ROOT_LOW) return glpd_pkg::ROOT_LOW;
      if (m > glpd_pkg::ROOT_HIGH) return glpd_pkg::ROOT_HIGH;
      return m;
   endfunction

   function automatic int unsigned cap_code(int unsigned c);
      return c < 4096 ? c : 0;
   endfunction

   function automatic void dict_reload();
      int unsigned clr;
      clr = 1 << root_of(min_size);
      for (int i = 0; i < clr; i++) begin
         dict_prefix[i] = 0;
         dict_suffix[i] = i[7:0];
         dict_len[i] = 0;
      end
      width = root_of(min_size) + 1;
      last_code = clr + 1;
      grow_at = 2 * clr;
   endfunction

   function automatic void decoder_restart();
      str_len = 0;
      str_pos = 0;
      bit_acc = 0;
      bit_cnt = 0;
      block_left = 0;
      err_state = glpd_pkg::ST_OK;
      dict_reload();
      prev_code = 1 << root_of(min_size);
   endfunction

   function automatic void load_string(int unsigned code);
      int unsigned c, k;
      c = cap_code(code);
      k = dict_len[c] + 1;
      str_len = k;
      str_pos = 0;
      while (k > 0) begin
         k--;
         if (k < 4096) str_buf[k] = dict_suffix[c];
         c = cap_code(dict_prefix[c]);
      end
   endfunction

   function automatic logic [7:0] head_char(int unsigned code);
      int unsigned c, n;
      c = cap_code(code);
      n = dict_len[c];
      while (n > 0) begin
         n--;
         c = cap_code(dict_prefix[c]);
      end
      return dict_suffix[c];
   endfunction

   function automatic void add_string(int unsigned at, logic [7:0] first);
      int unsigned p, len;
      p = cap_code(prev_code);
      len = dict_len[p] + 1;
      if (len > 4095) len = 4095;
      at = cap_code(at);
      dict_prefix[at] = p[11:0];
      dict_len[at] = len[11:0];
      dict_suffix[at] = first;
      last_code = at;
   endfunction

   function automatic void decode_one(int unsigned code);
      int unsigned clr;
      bit room;
      clr = 1 << root_of(min_size);
      room = last_code + 1 < 4096;
      if (code == clr) begin
         dict_reload();
         prev_code = clr;
         return;
      end
      if (code == clr + 1) return;
      if (code <= last_code) begin
         load_string(code);
         if (prev_code != clr && room) add_string(last_code + 1, str_buf[0]);
         prev_code = code;
      end else if (code == last_code + 1 && prev_code != clr && room) begin
         add_string(code, head_char(prev_code));
         load_string(code);
         prev_code = code;
      end else begin
         err_state = glpd_pkg::ST_BAD_CODE;
         return;
      end
      if (last_code + 1 == grow_at && width < 12) begin
         width++;
         grow_at = grow_at << 1;
      end
   endfunction

   function automatic glpd_pkg::rsp_type decoder_step(glpd_pkg::req_type q);
      glpd_pkg::rsp_type r;
      int unsigned code;
      r = '0;
      case (q.opcode)
         glpd_pkg::OP_PUSH: begin
            if (err_state != glpd_pkg::ST_OK) begin
               r.byte_accepted = 1;
            end else if (block_left == 0) begin
               r.byte_accepted = 1;
               if (q.data_byte == 0) err_state = glpd_pkg::ST_ZERO_LEN;
               else block_left = q.data_byte;
            end else if (bit_cnt + 8 <= 24) begin
               r.byte_accepted = 1;
               bit_acc = (bit_acc | (int'(q.data_byte) << bit_cnt)) & 32'hFFFFFF;
               bit_cnt += 8;
               block_left--;
            end
         end
         glpd_pkg::OP_PULL: begin
            while (err_state == glpd_pkg::ST_OK && str_pos >= str_len) begin
               if (bit_cnt < width) begin
                  r.need_byte = 1;
                  break;
               end
               code = bit_acc & ((1 << width) - 1);
               bit_acc = bit_acc >> width;
               bit_cnt -= width;
               decode_one(code);
            end
            if (err_state == glpd_pkg::ST_OK && !r.need_byte) begin
               r.pixel = str_pos < 4096 ? str_buf[str_pos] : 8'd0;
               str_pos++;
               r.pixel_valid = 1;
            end
         end
         glpd_pkg::OP_RESTART: decoder_restart();
         default: ;
      endcase
      r.status = err_state[1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      fail_cnt++;
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send(glpd_pkg::op_type op, logic [7:0] data, bit typed,
                       glpd_pkg::rsp_type typed_rsp, output glpd_pkg::rsp_type r);
      glpd_pkg::req_type q;
      q.opcode = op;
      q.data_byte = data;
      r = decoder_step(q);
      due_rsp_q.push_back(typed ? typed_rsp : r);
      req_cnt++;
      req_payload <= q;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (send_idle && $urandom_range(99) < send_pct) begin
         req_valid <= 0;
         req_payload <= glpd_pkg::req_type'(10'($urandom));
         @(negedge clock);
         while ($urandom_range(99) < send_pct) @(negedge clock);
      end
   endtask

   task automatic write_min_size(logic [3:0] v);
      glpd_pkg::rsp_type r;
      req_valid <= 0;
      while (due_rsp_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      min_size = v;
      send(glpd_pkg::OP_RESTART, 8'd0, 0, '0, r);
   endtask

   // build a code stream for the current code size, sometimes ending in an invalid code
   task automatic build_stream(int ncodes, bit literals);
      logic [7:0] raw [$];
      int unsigned clr, gf, gw, glim, code, acc, nb, len;
      bit pc;
      int p;
      clr = 1 << root_of(min_size);
      gf = clr + 1;
      gw = root_of(min_size) + 1;
      glim = 2 * clr;
      pc = 1;
      acc = clr;
      nb = gw;
      for (int i = 0; i < ncodes; i++) begin
         while (nb >= 8) begin
            raw.push_back(acc[7:0]);
            acc = acc >> 8;
            nb -= 8;
         end
         p = $urandom_range(99);
         if (p < 2 && !pc && !literals) begin
            code = clr;
            gf = clr + 1;
            gw = root_of(min_size) + 1;
            glim = 2 * clr;
            pc = 1;
            acc |= code << nb;
            nb += root_of(min_size) + 1;
            continue;
         end
         if (p < 3 && !literals) begin
            acc |= (clr + 1) << nb;
            nb += gw;
            continue;
         end
         if (p < 4 && !literals && gf + 2 < (1 << gw)) begin
            acc |= $urandom_range((1 << gw) - 1, gf + 2) << nb;
            nb += gw;
            break;
         end
         if (p < 30 && !literals && !pc && gf + 1 < 4096) code = gf + 1;
         else if (p < 60 && gf >= clr + 2 && (!literals || i > ncodes - 20))
            code = $urandom_range(gf, clr + 2);
         else code = $urandom_range(clr - 1, 0);
         acc |= code << nb;
         nb += gw;
         if (!pc && gf + 1 < 4096) gf++;
         pc = 0;
         if (gf + 1 == glim && gw < 12) begin
            gw++;
            glim = glim << 1;
         end
      end
      if ($urandom_range(1)) begin
         acc |= (clr + 1) << nb;
         nb += gw;
      end
      while (nb > 0) begin
         raw.push_back(acc[7:0]);
         acc = acc >> 8;
         nb = nb > 8 ? nb - 8 : 0;
      end
      stream_q.delete();
      while (raw.size() != 0) begin
         len = $urandom_range(99) < 80 ? $urandom_range(8, 1) : $urandom_range(255, 1);
         if (len > raw.size()) len = raw.size();
         stream_q.push_back(len[7:0]);
         repeat (len) stream_q.push_back(raw.pop_front());
      end
      if ($urandom_range(99) < 30) stream_q.push_back(8'd0);
   endtask

   // feed the stream, pulling pixels in between (with occasional no-ops and, when noisy, random requests), then drain
   task automatic play_stream(bit noisy);
      glpd_pkg::rsp_type r;
      int guard;
      while (stream_q.size() != 0) begin
         if (noisy && $urandom_range(99) < 3) begin
            send(glpd_pkg::op_type'($urandom_range(3)), 8'($urandom), 0, '0, r);
         end else if ($urandom_range(99) < 45 ||
                      (err_state == glpd_pkg::ST_OK && block_left != 0 &&
                       bit_cnt + 8 > 24)) begin
            send($urandom_range(99) < 3 ? glpd_pkg::OP_NOP : glpd_pkg::OP_PULL,
                 8'($urandom), 0, '0, r);
         end else begin
            send(glpd_pkg::OP_PUSH, stream_q.pop_front(), 0, '0, r);
         end
      end
      guard = 0;
      do begin
         send(glpd_pkg::OP_PULL, 8'($urandom), 0, '0, r);
         guard++;
      end while (r.pixel_valid && guard < 20000);
   endtask

   function automatic void set_idle(int m);
      send_idle = (m == 1 || m == 3);
      recv_idle = (m == 2 || m == 3);
      send_pct = m == 3 ? 28 : 86;
      recv_pct = m == 3 ? 28 : 86;
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= recv_idle && ($urandom_range(99) < recv_pct);
   end

   always @(posedge clock) begin
      glpd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_cnt++;
         if (due_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload, 0);
         end else begin
            want = due_rsp_q.pop_front();
            if (rsp_payload.pixel_valid) pixel_cnt++;
            if (rsp_payload.pixel != want.pixel)
               report_mismatch("pixel", rsp_payload.pixel, want.pixel);
            if (rsp_payload.pixel_valid != want.pixel_valid)
               report_mismatch("pixel_valid", rsp_payload.pixel_valid, want.pixel_valid);
            if (rsp_payload.byte_accepted != want.byte_accepted)
               report_mismatch("byte_accepted", rsp_payload.byte_accepted,
                               want.byte_accepted);
            if (rsp_payload.need_byte != want.need_byte)
               report_mismatch("need_byte", rsp_payload.need_byte, want.need_byte);
            if (rsp_payload.status != want.status)
               report_mismatch("status", rsp_payload.status, want.status);
         end
      end
   end

   function automatic plan_row_type row(glpd_pkg::op_type op, logic [7:0] d, bit typed,
                                        logic [7:0] px, logic pv, logic ba, logic nb,
                                        logic [1:0] st);
      plan_row_type x;
      x.op = op;
      x.data = d;
      x.typed = typed;
      x.rsp = '{pixel: px, pixel_valid: pv, byte_accepted: ba, need_byte: nb, status: st};
      return x;
   endfunction

   initial begin
      glpd_pkg::rsp_type r;
      logic [3:0] sizes [8] = '{4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd7, 4'd8, 4'd4};
      int phase_start;
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_data = '0;
      for (int i = 0; i < 4096; i++) begin
         dict_prefix[i] = 0;
         dict_suffix[i] = 0;
         dict_len[i] = 0;
         str_buf[i] = 0;
      end
      min_size = glpd_pkg::CFG_RESET;
      decoder_restart();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // empty pull, zero-length block, bad code, sticky error, full accumulator
      plan.push_back(row(glpd_pkg::OP_NOP,     8'h00, 1, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'hFF, 1, 0, 0, 0, 1, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h00, 1, 0, 0, 1, 0, glpd_pkg::ST_ZERO_LEN));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'hAA, 1, 0, 0, 1, 0, glpd_pkg::ST_ZERO_LEN));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 1, 0, 0, 0, 0, glpd_pkg::ST_ZERO_LEN));
      plan.push_back(row(glpd_pkg::OP_RESTART, 8'h00, 1, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h02, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'hFF, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h01, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 1, 0, 0, 0, 0, glpd_pkg::ST_BAD_CODE));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h55, 1, 0, 0, 1, 0, glpd_pkg::ST_BAD_CODE));
      plan.push_back(row(glpd_pkg::OP_RESTART, 8'hFF, 1, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h05, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h00, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h01, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h02, 1, 0, 0, 1, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h03, 1, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'h03, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PUSH,    8'hFF, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_PULL,    8'h00, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      plan.push_back(row(glpd_pkg::OP_NOP,     8'hFF, 0, 0, 0, 0, 0, glpd_pkg::ST_OK));
      foreach (plan[i]) send(plan[i].op, plan[i].data, plan[i].typed, plan[i].rsp, r);

      for (int ph = 0; ph < 8; ph++) begin
         set_idle(ph % 4);
         write_min_size(sizes[ph]);
         phase_start = req_cnt;
         while (req_cnt - phase_start < 180) begin
            build_stream($urandom_range(99) < 85 ? $urandom_range(30, 5)
                                                 : $urandom_range(80, 30), 0);
            play_stream($urandom_range(99) < 10);
            send(glpd_pkg::OP_RESTART, 8'($urandom), 0, '0, r);
         end
      end
      req_valid <= 0;

      while (due_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("%0d requests, %0d responses, %0d pixels decoded", req_cnt, rsp_cnt, pixel_cnt);
      $display("code sizes 2 to 8 incl. clamped values, code and block errors, four idle mixes");
      if (fail_cnt == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
